// ===== rtl/core/mcfhs_pkg.sv =====
// shared constants, codes and types of the split-flap homing sequencer
package mcfhs_pkg;

    localparam int CHANNEL_COUNT_DEF = 32;
    localparam int INDEX_BITS_DEF    = 7;

    // sensor and coil ports are fixed at this width, channels above read as home
    localparam int SENSOR_WIDTH    = 32;
    localparam int SENSOR_EXT      = 64;
    localparam int SENSOR_IDX_BITS = 6;

    // request codes
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_HOME = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    // run modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_MOVE = 2'd1;
    localparam logic [1:0] MODE_HOME = 2'd2;

    // per-channel decisions of one served channel
    typedef struct packed {
        logic toggle;
        logic set_zeroed;
        logic miss;
    } serve_ctl_t;

endpackage

// ===== rtl/core/mcfhs_chan_mem.sv =====
// per-channel entry memory, one write port and one registered read port
module mcfhs_chan_mem #(
    parameter int DEPTH      = mcfhs_pkg::CHANNEL_COUNT_DEF,
    parameter int ADDR_BITS  = 5,
    parameter int DATA_BITS  = 3 * mcfhs_pkg::INDEX_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mcfhs_serve.sv =====
// service decision for the one channel handled by a tick
module mcfhs_serve #(
    parameter int INDEX_BITS = mcfhs_pkg::INDEX_BITS_DEF
) (
    input  logic                   mode_move,
    input  logic [INDEX_BITS-1:0]  tgt,
    input  logic [INDEX_BITS-1:0]  prog,
    input  logic [INDEX_BITS-1:0]  cur,
    input  logic                   zeroed,
    input  logic                   home,
    output logic [INDEX_BITS-1:0]  prog_next,
    output mcfhs_pkg::serve_ctl_t  ctl
);

    logic skip;
    logic step;
    logic seek;

    always_comb
    begin
        skip      = (cur != '0) && (cur == tgt);
        step      = 1'b0;
        seek      = 1'b0;
        prog_next = prog;
        ctl       = '0;
        if (mode_move)
        begin
            if (skip)
            begin
                prog_next = tgt;
            end
            else
            begin
                // zeroed channels count flaps, unzeroed ones hunt for home
                step           = zeroed && (prog < tgt);
                seek           = !home && !zeroed;
                prog_next      = step ? prog + 1'b1 : prog;
                ctl.toggle     = step | seek;
                ctl.set_zeroed = !seek;
            end
            ctl.miss = (prog_next != tgt);
        end
        else
        begin
            ctl.toggle = !home;
            ctl.miss   = !home;
        end
    end

endmodule

// ===== rtl/core/multi_channel_flap_homing_sequencer.sv =====
// top level of the multi-channel split-flap homing sequencer
// an accepted beat is read from the channel entry memory and latched, then its
//   result is registered in the write-back state; no new item is taken until the
//   read-modify-write of the entry is through (read on accept, write back next cycle)
// reset: all progress and current indices read as zero, coils off, idle,
//   scan pointer zero; target memory holds no value until loaded
module multi_channel_flap_homing_sequencer #(
    parameter int CHANNEL_COUNT = mcfhs_pkg::CHANNEL_COUNT_DEF,
    parameter int INDEX_BITS    = mcfhs_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [4:0]  channel,
    input  logic [6:0]  target_index,
    input  logic [31:0] home_sensors,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] coil_bits,
    output logic        driver_enable,
    output logic        busy_res,
    output logic        done_res
);

    localparam int CH_BITS      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int ENTRY_BITS   = 3 * INDEX_BITS;
    localparam int SENSOR_EXT_W = mcfhs_pkg::SENSOR_EXT;

    // two-phase sequencer: accept and read, then modify and write back
    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_EXEC   = 1'b1;

    logic state_reg, state_next;

    // latched item
    logic [1:0]            req_reg;
    logic [INDEX_BITS-1:0] tidx_reg;
    logic                  ld_ok_reg;
    logic [CH_BITS-1:0]    addr_reg;
    logic [31:0]           sens_reg;

    // sequencing state
    logic [1:0]               mode_reg, mode_next;
    logic [CH_BITS-1:0]       sp_reg, sp_next;
    logic                     pass_reg, pass_next;
    logic [CHANNEL_COUNT-1:0] zeroed_reg, zeroed_next;
    logic [CHANNEL_COUNT-1:0] coil_reg, coil_next;

    // per-entry views of the memory: progress valid, current follows target,
    // current forced to zero; all clear means the stored current is used
    logic [CHANNEL_COUNT-1:0] prog_valid_reg, prog_valid_next;
    logic [CHANNEL_COUNT-1:0] cur_track_reg, cur_track_next;
    logic [CHANNEL_COUNT-1:0] cur_zero_reg, cur_zero_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] coil_out_reg;
    logic        busy_out_reg;
    logic        done_out_reg;

    // input side
    logic                  in_accept;
    logic                  out_accept;
    logic [31:0]           ch_wide;
    logic [31:0]           tidx_wide;
    logic                  ld_ok_in;
    logic [CH_BITS-1:0]    ch_in;
    logic [CH_BITS-1:0]    rd_addr;

    // memory and service logic
    logic                  wr_en;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [INDEX_BITS-1:0] tgt_m, prog_m, cur_m;
    logic [INDEX_BITS-1:0] prog_eff, cur_eff, prog_srv;
    logic [SENSOR_EXT_W-1:0] sens_ext;
    logic                  home_ch;
    logic                  pass_eff;
    logic                  done;
    logic [SENSOR_EXT_W-1:0] coil_ext;
    mcfhs_pkg::serve_ctl_t ctl;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // accept only when the result register will be free at write-back
    assign in_stall = (state_reg != ST_ACCEPT) || (out_valid_reg && out_stall);

    assign ch_wide   = 32'(channel);
    assign tidx_wide = 32'(target_index);
    assign ld_ok_in  = ch_wide < CHANNEL_COUNT;
    assign ch_in     = ch_wide[CH_BITS-1:0];
    assign rd_addr   = (req_type == mcfhs_pkg::REQ_LOAD) ? ch_in : sp_reg;

    mcfhs_chan_mem #(
        .DEPTH     (CHANNEL_COUNT),
        .ADDR_BITS (CH_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // entry layout: target, progress, current
    assign tgt_m  = rd_data[ENTRY_BITS-1 -: INDEX_BITS];
    assign prog_m = rd_data[2*INDEX_BITS-1 -: INDEX_BITS];
    assign cur_m  = rd_data[INDEX_BITS-1:0];

    assign prog_eff = prog_valid_reg[addr_reg] ? prog_m : '0;
    assign cur_eff  = cur_zero_reg[addr_reg]  ? '0 :
                      cur_track_reg[addr_reg] ? tgt_m : cur_m;

    // channels beyond the sensor port count as home
    assign sens_ext = {{(SENSOR_EXT_W - mcfhs_pkg::SENSOR_WIDTH){1'b1}}, sens_reg};
    assign home_ch  = sens_ext[mcfhs_pkg::SENSOR_IDX_BITS'(addr_reg)];

    mcfhs_serve #(
        .INDEX_BITS (INDEX_BITS)
    ) u_serve (
        .mode_move (mode_reg == mcfhs_pkg::MODE_MOVE),
        .tgt       (tgt_m),
        .prog      (prog_eff),
        .cur       (cur_eff),
        .zeroed    (zeroed_reg[addr_reg]),
        .home      (home_ch),
        .prog_next (prog_srv),
        .ctl       (ctl)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        sp_next         = sp_reg;
        pass_next       = pass_reg;
        zeroed_next     = zeroed_reg;
        coil_next       = coil_reg;
        prog_valid_next = prog_valid_reg;
        cur_track_next  = cur_track_reg;
        cur_zero_next   = cur_zero_reg;
        wr_en           = 1'b0;
        wr_data         = {tgt_m, prog_eff, cur_eff};
        pass_eff        = pass_reg;
        done            = 1'b0;

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_ACCEPT;
                unique case (req_reg)
                    mcfhs_pkg::REQ_LOAD:
                    begin
                        // write back resolved fields so the entry stands alone
                        if (ld_ok_reg)
                        begin
                            wr_en                     = 1'b1;
                            wr_data                   = {tidx_reg, prog_eff, cur_eff};
                            prog_valid_next[addr_reg] = 1'b1;
                            cur_track_next[addr_reg]  = 1'b0;
                            cur_zero_next[addr_reg]   = 1'b0;
                        end
                    end
                    mcfhs_pkg::REQ_MOVE:
                    begin
                        if (mode_reg == mcfhs_pkg::MODE_IDLE)
                        begin
                            // progress cleared for all channels at once
                            prog_valid_next = '0;
                            zeroed_next     = sens_ext[CHANNEL_COUNT-1:0];
                            mode_next       = mcfhs_pkg::MODE_MOVE;
                            sp_next         = '0;
                            pass_next       = 1'b1;
                        end
                    end
                    mcfhs_pkg::REQ_HOME:
                    begin
                        if (mode_reg == mcfhs_pkg::MODE_IDLE)
                        begin
                            mode_next = mcfhs_pkg::MODE_HOME;
                            sp_next   = '0;
                            pass_next = 1'b1;
                        end
                    end
                    mcfhs_pkg::REQ_TICK:
                    begin
                        if (mode_reg != mcfhs_pkg::MODE_IDLE)
                        begin
                            if (mode_reg == mcfhs_pkg::MODE_MOVE)
                            begin
                                wr_en                     = 1'b1;
                                wr_data                   = {tgt_m, prog_srv, cur_eff};
                                prog_valid_next[addr_reg] = 1'b1;
                                cur_track_next[addr_reg]  = 1'b0;
                                cur_zero_next[addr_reg]   = 1'b0;
                                if (ctl.set_zeroed)
                                begin
                                    zeroed_next[addr_reg] = 1'b1;
                                end
                            end
                            coil_next[addr_reg] = coil_reg[addr_reg] ^ ctl.toggle;
                            pass_eff            = pass_reg && !ctl.miss;
                            if (addr_reg == CH_BITS'(CHANNEL_COUNT - 1))
                            begin
                                if (pass_eff)
                                begin
                                    // every current index follows the run's end point
                                    done      = 1'b1;
                                    mode_next = mcfhs_pkg::MODE_IDLE;
                                    if (mode_reg == mcfhs_pkg::MODE_MOVE)
                                    begin
                                        cur_track_next = '1;
                                        cur_zero_next  = '0;
                                    end
                                    else
                                    begin
                                        cur_track_next = '0;
                                        cur_zero_next  = '1;
                                    end
                                end
                                pass_next = 1'b1;
                                sp_next   = '0;
                            end
                            else
                            begin
                                pass_next = pass_eff;
                                sp_next   = addr_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
        endcase
    end

    assign coil_ext = SENSOR_EXT_W'(coil_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_EXEC)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_ACCEPT;
            mode_reg       <= mcfhs_pkg::MODE_IDLE;
            sp_reg         <= '0;
            pass_reg       <= 1'b1;
            zeroed_reg     <= '0;
            coil_reg       <= '0;
            prog_valid_reg <= '0;
            cur_track_reg  <= '0;
            cur_zero_reg   <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            sp_reg         <= sp_next;
            pass_reg       <= pass_next;
            zeroed_reg     <= zeroed_next;
            coil_reg       <= coil_next;
            prog_valid_reg <= prog_valid_next;
            cur_track_reg  <= cur_track_next;
            cur_zero_reg   <= cur_zero_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg   <= req_type;
            tidx_reg  <= tidx_wide[INDEX_BITS-1:0];
            ld_ok_reg <= ld_ok_in;
            addr_reg  <= rd_addr;
            sens_reg  <= home_sensors;
        end
        if (state_reg == ST_EXEC)
        begin
            coil_out_reg <= coil_ext[31:0];
            busy_out_reg <= (mode_next != mcfhs_pkg::MODE_IDLE);
            done_out_reg <= done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coil_bits     = coil_out_reg;
    assign driver_enable = busy_out_reg;
    assign busy_res      = busy_out_reg;
    assign done_res      = done_out_reg;

`ifndef SYNTHESIS
    // one item in flight: input closed in the cycle after an accept
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input accepted during write-back");

    // each accepted beat yields a result beat once its write-back is registered
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> ##1 out_valid)
        else $error("result beat missing after accept");

    // a completed sequence leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && !driver_enable))
        else $error("done reported while still busy");

    // scan pointer stays on a real channel
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) < CHANNEL_COUNT)
        else $error("scan pointer out of range");
`endif

endmodule

// ===== sim/tb_multi_channel_flap_homing_sequencer.sv =====
// testbench of the split-flap homing sequencer: directed table, then random beats
module tb_multi_channel_flap_homing_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH         = mcfhs_pkg::CHANNEL_COUNT_DEF;
    localparam int RANDOM_ITEMS = 550;
    // targets used by moves stay small so that a move ends within a few passes
    localparam int SMALL_TGT    = 3;
    localparam int MAX_GAP      = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIRECTED   = 17;

    // idling per phase of the random part: none, sender, receiver, both
    localparam int GAP_PCT   [4] = '{0, 55, 0, 36};
    localparam int STALL_PCT [4] = '{0, 0, 55, 36};

    // one result beat of the block
    typedef struct packed {
        logic [31:0] coil;
        logic        enable;
        logic        busy;
        logic        done;
    } flap_drive_t;

    // one row of the directed table; typed rows carry their result
    typedef struct packed {
        logic [1:0]  req;
        logic [4:0]  ch;
        logic [6:0]  tgt;
        logic [31:0] sensors;
        logic        typed;
        flap_drive_t drive;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = mcfhs_pkg::REQ_TICK;
    logic [4:0]  channel = '0;
    logic [6:0]  target_index = '0;
    logic [31:0] home_sensors = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] coil_bits;
    logic        driver_enable;
    logic        busy_res;
    logic        done_res;

    int gap_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int work_items = 0;

    // drive results still owed by the block, oldest first
    flap_drive_t drive_expect_q[$];

    // sequencer state as the testbench sees it
    logic [6:0]  tgt_mem  [N_CH];
    logic [6:0]  prog_mem [N_CH];
    logic [6:0]  cur_mem  [N_CH];
    logic [31:0] zeroed_mask = '0;
    logic [31:0] coil_state = '0;
    logic [1:0]  run_mode = mcfhs_pkg::MODE_IDLE;
    logic [4:0]  scan_ptr = '0;
    logic        pass_clean = 1'b1;

    // directed rows: idle ticks, field extremes, homing start, starts and a load
    // while busy; rows whose result is obvious carry it, the rest go to the model
    stim_row_t directed_rows [N_DIRECTED] = '{
        // tick while idle, all fields low and all fields high
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{mcfhs_pkg::REQ_TICK, 5'd31, 7'd127, 32'hFFFF_FFFF, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        // target loads at the extremes and with alternating bits
        '{mcfhs_pkg::REQ_LOAD, 5'd0,  7'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{mcfhs_pkg::REQ_LOAD, 5'd31, 7'd127, 32'hFFFF_FFFF, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{mcfhs_pkg::REQ_LOAD, 5'd21, 7'h55,  32'hAAAA_AAAA, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        '{mcfhs_pkg::REQ_LOAD, 5'd10, 7'h2A,  32'h5555_5555, 1'b1,
          '{32'h0, 1'b0, 1'b0, 1'b0}},
        // homing start, first channel away from home flips, second sits at home
        '{mcfhs_pkg::REQ_HOME, 5'd0,  7'd0,   32'h0000_0000, 1'b1,
          '{32'h0, 1'b1, 1'b1, 1'b0}},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'h0000_0000, 1'b1,
          '{32'h1, 1'b1, 1'b1, 1'b0}},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'hFFFF_FFFF, 1'b1,
          '{32'h1, 1'b1, 1'b1, 1'b0}},
        // starts while a run is active are dropped
        '{mcfhs_pkg::REQ_MOVE, 5'd7,  7'd9,   32'h0000_0000, 1'b0, '0},
        '{mcfhs_pkg::REQ_HOME, 5'd3,  7'd1,   32'hFFFF_FFFF, 1'b0, '0},
        // a load while busy lands at once
        '{mcfhs_pkg::REQ_LOAD, 5'd5,  7'd3,   32'h0000_0000, 1'b0, '0},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'h0000_0000, 1'b0, '0},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'hFFFF_0000, 1'b0, '0},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'h0000_0010, 1'b0, '0},
        '{mcfhs_pkg::REQ_TICK, 5'd0,  7'd0,   32'hDEAD_BEEF, 1'b0, '0},
        '{mcfhs_pkg::REQ_MOVE, 5'd0,  7'd0,   32'h0000_0000, 1'b0, '0}
    };

    multi_channel_flap_homing_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .channel       (channel),
        .target_index  (target_index),
        .home_sensors  (home_sensors),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coil_bits     (coil_bits),
        .driver_enable (driver_enable),
        .busy_res      (busy_res),
        .done_res      (done_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // apply one beat to the sequencer state and work out the drive it leaves;
    // a start while busy and a tick while idle change nothing
    task automatic advance_flap_model(input logic [1:0] req, input logic [4:0] ch,
                                      input logic [6:0] tv, input logic [31:0] sens,
                                      output flap_drive_t res);
        logic [4:0] c;
        logic [6:0] t;
        logic       z;
        logic       seq_done;
        seq_done = 1'b0;
        case (req)
            mcfhs_pkg::REQ_LOAD:
            begin
                tgt_mem[ch] = tv;
            end
            mcfhs_pkg::REQ_MOVE, mcfhs_pkg::REQ_HOME:
            begin
                if (run_mode == mcfhs_pkg::MODE_IDLE)
                begin
                    if (req == mcfhs_pkg::REQ_MOVE)
                    begin
                        // channels already at home count as zeroed from the start
                        for (int i = 0; i < N_CH; i++)
                            prog_mem[i] = '0;
                        zeroed_mask = sens;
                        run_mode = mcfhs_pkg::MODE_MOVE;
                    end
                    else
                    begin
                        run_mode = mcfhs_pkg::MODE_HOME;
                    end
                    scan_ptr = '0;
                    pass_clean = 1'b1;
                end
            end
            default:
            begin
                if (run_mode != mcfhs_pkg::MODE_IDLE)
                begin
                    c = scan_ptr;
                    if (run_mode == mcfhs_pkg::MODE_MOVE)
                    begin
                        t = tgt_mem[c];
                        if (cur_mem[c] != '0 && cur_mem[c] == t)
                        begin
                            // already showing its target: skipped, nothing flips
                            prog_mem[c] = t;
                        end
                        else
                        begin
                            z = zeroed_mask[c];
                            if (z && prog_mem[c] < t)
                            begin
                                prog_mem[c] = prog_mem[c] + 7'd1;
                                coil_state[c] = ~coil_state[c];
                            end
                            if (!sens[c] && !z)
                                coil_state[c] = ~coil_state[c];
                            else
                                zeroed_mask[c] = 1'b1;
                        end
                        if (prog_mem[c] != t)
                            pass_clean = 1'b0;
                    end
                    else if (!sens[c])
                    begin
                        coil_state[c] = ~coil_state[c];
                        pass_clean = 1'b0;
                    end
                    // end of a pass: a clean pass finishes the run
                    if (c == 5'(N_CH - 1))
                    begin
                        if (pass_clean)
                        begin
                            for (int i = 0; i < N_CH; i++)
                                cur_mem[i] = (run_mode == mcfhs_pkg::MODE_MOVE) ?
                                             tgt_mem[i] : '0;
                            run_mode = mcfhs_pkg::MODE_IDLE;
                            seq_done = 1'b1;
                        end
                        pass_clean = 1'b1;
                        scan_ptr = '0;
                    end
                    else
                    begin
                        scan_ptr = c + 5'd1;
                    end
                end
            end
        endcase
        res.coil = coil_state;
        res.enable = (run_mode != mcfhs_pkg::MODE_IDLE);
        res.busy = (run_mode != mcfhs_pkg::MODE_IDLE);
        res.done = seq_done;
    endtask

    // present one beat, wait for the handshake and book its drive result;
    // a typed row books the result written in the table
    task automatic send_beat(input logic [1:0] req, input logic [4:0] ch,
                             input logic [6:0] tv, input logic [31:0] sens,
                             input logic typed, input flap_drive_t typed_drive);
        flap_drive_t res;
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        channel <= ch;
        target_index <= tv;
        home_sensors <= sens;
        // inputs only move at rising edges, so stall is settled at the falling one
        do
            @(negedge clk);
        while (in_stall);
        advance_flap_model(req, ch, tv, sens, res);
        drive_expect_q.push_back(typed ? typed_drive : res);
        work_items++;
        @(posedge clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(1, 100) <= stall_pct);
    end

    // result beats: taken at the edge after a falling edge that shows valid without stall
    always @(negedge clk)
    begin
        flap_drive_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expect_q.size() == 0)
            begin
                $error("result beat with no expectation: coil_bits %h", coil_bits);
                fail_count++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                if (coil_bits !== want.coil)
                begin
                    $error("coil_bits expected %h actual %h", want.coil, coil_bits);
                    fail_count++;
                end
                if (driver_enable !== want.enable)
                begin
                    $error("driver_enable expected %0d actual %0d", want.enable,
                           driver_enable);
                    fail_count++;
                end
                if (busy_res !== want.busy)
                begin
                    $error("busy_res expected %0d actual %0d", want.busy, busy_res);
                    fail_count++;
                end
                if (done_res !== want.done)
                begin
                    $error("done_res expected %0d actual %0d", want.done, done_res);
                    fail_count++;
                end
            end
        end
    end

    // watchdog over the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int          noisy_ticks;
        int          run_ticks;
        int          pick;
        logic [4:0]  ch;
        logic [6:0]  lo;
        noisy_ticks = 0;
        run_ticks = 0;
        for (int i = 0; i < N_CH; i++)
        begin
            tgt_mem[i] = '0;
            prog_mem[i] = '0;
            cur_mem[i] = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(directed_rows[r].req, directed_rows[r].ch, directed_rows[r].tgt,
                      directed_rows[r].sensors, directed_rows[r].typed,
                      directed_rows[r].drive);

        // every target gets a value before any move can read it
        for (int i = 0; i < N_CH; i++)
            send_beat(mcfhs_pkg::REQ_LOAD, 5'(i), 7'($urandom_range(0, SMALL_TGT)),
                      $urandom, 1'b0, '0);

        while (work_items < RANDOM_ITEMS)
        begin
            pick = (work_items * 4) / RANDOM_ITEMS;
            gap_pct = GAP_PCT[pick];
            stall_pct = STALL_PCT[pick];

            if (run_mode == mcfhs_pkg::MODE_IDLE)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // noise while idle: a dead tick, or a load of any value
                    if ($urandom_range(0, 1) == 0)
                        send_beat(mcfhs_pkg::REQ_TICK, 5'($urandom), 7'($urandom),
                                  $urandom, 1'b0, '0);
                    else
                        send_beat(mcfhs_pkg::REQ_LOAD, 5'($urandom), 7'($urandom),
                                  $urandom, 1'b0, '0);
                end
                else
                begin
                    // a few new targets, oversized ones pulled back, then a start
                    repeat ($urandom_range(0, 3))
                        send_beat(mcfhs_pkg::REQ_LOAD, 5'($urandom),
                                  ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                              : 7'($urandom_range(0, SMALL_TGT)),
                                  $urandom, 1'b0, '0);
                    for (int i = 0; i < N_CH; i++)
                        if (tgt_mem[i] > 7'(SMALL_TGT))
                            send_beat(mcfhs_pkg::REQ_LOAD, 5'(i),
                                      7'($urandom_range(0, SMALL_TGT)),
                                      $urandom, 1'b0, '0);
                    noisy_ticks = $urandom_range(0, 48);
                    run_ticks = 0;
                    send_beat(($urandom_range(0, 9) < 7) ? mcfhs_pkg::REQ_MOVE
                                                         : mcfhs_pkg::REQ_HOME,
                              5'($urandom), 7'($urandom),
                              ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'($urandom),
                              1'b0, '0);
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 90)
                begin
                    // sensors scatter early in a run, then all channels sit at home
                    send_beat(mcfhs_pkg::REQ_TICK, 5'($urandom), 7'($urandom),
                              (run_ticks < noisy_ticks) ? 32'($urandom) : 32'hFFFF_FFFF,
                              1'b0, '0);
                    run_ticks++;
                end
                else if (pick < 95)
                begin
                    send_beat(($urandom_range(0, 1) == 0) ? mcfhs_pkg::REQ_MOVE
                                                          : mcfhs_pkg::REQ_HOME,
                              5'($urandom), 7'($urandom), $urandom, 1'b0, '0);
                end
                else
                begin
                    // load while busy, never below the progress already made
                    ch = 5'($urandom);
                    lo = (prog_mem[ch] > 7'(SMALL_TGT)) ? 7'(SMALL_TGT) : prog_mem[ch];
                    send_beat(mcfhs_pkg::REQ_LOAD, ch, 7'($urandom_range(lo, SMALL_TGT)),
                              $urandom, 1'b0, '0);
                end
            end
        end

        in_valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mcfhs_pkg.sv
rtl/core/mcfhs_chan_mem.sv
rtl/core/mcfhs_serve.sv
rtl/core/multi_channel_flap_homing_sequencer.sv
sim/tb_multi_channel_flap_homing_sequencer.sv
